// File: design/nearest_target_gate_ema_assert.svh
// Assertion macros for the nearest target gate block.
// Used by nearest_target_gate_ema.sv; expects signals clk and rst_n in scope.
`ifndef NEAREST_TARGET_GATE_EMA_ASSERT_SVH
`define NEAREST_TARGET_GATE_EMA_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk once reset has been released.
`define NTGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, during reset as well.
`define NTGE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define NTGE_ASSERT(label, prop, msg)
`define NTGE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: design/ntge_pkg.sv
// Package for the nearest target gate block: widths, codes, reset values
// and the exponential averaging function. No dependencies.
`timescale 1ns / 1ps

package ntge_pkg;

    localparam int RANGE_W = 18;
    localparam int FIELD_W = 16;
    localparam int ALPHA_W = 17;
    localparam int TICK_W  = 16;
    localparam int BLEND_W = RANGE_W + 1;

    localparam logic [RANGE_W-1:0] ONE_KM_LIMIT = 18'd256000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'd65536;
    localparam logic [TICK_W-1:0]  TICK_MAX     = 16'hFFFF;

    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 18'd0;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 18'd25600;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 17'd6554;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST   = 16'd3000;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Request kinds carried in s_tuser.
    localparam logic [1:0] OP_DETECTION = 2'd0;
    localparam logic [1:0] OP_FRAME_END = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_MIN_RANGE = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE = 3'd1;
    localparam logic [2:0] REG_SMOOTHING = 3'd2;
    localparam logic [2:0] REG_ALPHA     = 3'd3;
    localparam logic [2:0] REG_TIMEOUT   = 3'd4;

    // held + floor(a * (x - held) / 65536). For a up to 65536 the result lies
    // between held and x, so it always fits back into the operand width.
    function automatic logic signed [BLEND_W-1:0] blend(
        input logic signed [BLEND_W-1:0] held,
        input logic signed [BLEND_W-1:0] x,
        input logic        [ALPHA_W-1:0] a
    );
        logic signed [BLEND_W:0]           diff;
        logic signed [BLEND_W+ALPHA_W+1:0] prod;
        logic signed [BLEND_W+2:0]         quot;
        logic signed [BLEND_W+2:0]         sum;
        diff = {x[BLEND_W-1], x} - {held[BLEND_W-1], held};
        prod = $signed({1'b0, a}) * diff;
        // Dropping the low 16 bits of a two's complement value is a floor.
        quot = prod[BLEND_W+ALPHA_W+1:16];
        sum  = {{3{held[BLEND_W-1]}}, held} + quot;
        return sum[BLEND_W-1:0];
    endfunction

endpackage

// File: design/nearest_target_gate_ema.sv
// Nearest target gate with exponential averaging, top level.
// Depends on ntge_pkg and nearest_target_gate_ema_assert.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Signals                                   Content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser         detection, frame end, tick
//  m_*       out        m_tvalid m_tready m_tdata                 held target at frame end
//  APB       in/out     psel penable pwrite paddr pwdata prdata   five config registers
//
//  Each request is held in the input register; the gate, the four averaging
//  multipliers and the state update run between it and the state and result
//  registers, so one request is taken every cycle unless a frame end waits.
//  m_tvalid rises after a frame end leaves the input register, if held range < ONE_KM_LIMIT.
//  A frame end waits in the input register only while the result register
//  is full and stalled; detections and ticks pass regardless.
//  Reset clears the control state and loads the register defaults at once.

`include "nearest_target_gate_ema_assert.svh"

module nearest_target_gate_ema
    import ntge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [17:0] det_range, [33:18] det_speed, [49:34] det_azimuth,
    // [65:50] det_elevation, [71:66] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [17:0] out_range, [33:18] out_speed, [49:34] out_azimuth,
    // [65:50] out_elevation, [71:66] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Configuration registers.
    logic [RANGE_W-1:0] min_range_reg;
    logic [RANGE_W-1:0] max_range_reg;
    logic               smoothing_on_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [TICK_W-1:0]  timeout_ticks_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg     <= MIN_RANGE_RST;
            max_range_reg     <= MAX_RANGE_RST;
            smoothing_on_reg  <= 1'b0;
            alpha_reg         <= ALPHA_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_RANGE: min_range_reg     <= pwdata[RANGE_W-1:0];
                REG_MAX_RANGE: max_range_reg     <= pwdata[RANGE_W-1:0];
                REG_SMOOTHING: smoothing_on_reg  <= pwdata[0];
                REG_ALPHA:     alpha_reg         <= pwdata[ALPHA_W-1:0];
                REG_TIMEOUT:   timeout_ticks_reg <= pwdata[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MIN_RANGE: prdata = {{(32-RANGE_W){1'b0}}, min_range_reg};
            REG_MAX_RANGE: prdata = {{(32-RANGE_W){1'b0}}, max_range_reg};
            REG_SMOOTHING: prdata = {31'd0, smoothing_on_reg};
            REG_ALPHA:     prdata = {{(32-ALPHA_W){1'b0}}, alpha_reg};
            REG_TIMEOUT:   prdata = {{(32-TICK_W){1'b0}}, timeout_ticks_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Input register.
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [RANGE_W-1:0] in_range_reg;
    logic [FIELD_W-1:0] in_speed_reg;
    logic [FIELD_W-1:0] in_azimuth_reg;
    logic [FIELD_W-1:0] in_elevation_reg;

    // Tracker state.
    logic [RANGE_W-1:0] held_range_reg,     held_range_next;
    logic [FIELD_W-1:0] held_speed_reg,     held_speed_next;
    logic [FIELD_W-1:0] held_azimuth_reg,   held_azimuth_next;
    logic [FIELD_W-1:0] held_elevation_reg, held_elevation_next;
    logic               tracking_valid_reg, tracking_valid_next;
    logic [RANGE_W-1:0] frame_nearest_reg,  frame_nearest_next;
    logic [TICK_W-1:0]  ticks_reg,          ticks_next;

    // Result register.
    logic                  out_valid_reg,  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic s_accept;
    logic in_is_frame_end;
    logic emit;
    logic out_free;
    logic in_fire;

    assign in_is_frame_end = (in_op_reg == OP_FRAME_END);
    assign emit            = in_is_frame_end && (held_range_reg < ONE_KM_LIMIT);
    assign out_free        = !out_valid_reg || m_tready;
    // A frame end needs the result register; other requests never block.
    assign in_fire         = in_valid_reg && (!in_is_frame_end || out_free);
    assign s_tready        = !in_valid_reg || in_fire;
    assign s_accept        = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg        <= s_tuser;
            in_range_reg     <= s_tdata[17:0];
            in_speed_reg     <= s_tdata[33:18];
            in_azimuth_reg   <= s_tdata[49:34];
            in_elevation_reg <= s_tdata[65:50];
        end
    end

    // Detection path: gate, timeout, nearest test and averaging.
    logic [ALPHA_W-1:0]        alpha_eff;
    logic                      in_gate;
    logic                      timed_out;
    logic                      track_now;
    logic                      nearer;
    logic signed [BLEND_W-1:0] avg_range;
    logic signed [BLEND_W-1:0] avg_speed;
    logic signed [BLEND_W-1:0] avg_azimuth;
    logic signed [BLEND_W-1:0] avg_elevation;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign in_gate   = (in_range_reg >= min_range_reg) && (in_range_reg <= max_range_reg);
    assign timed_out = ticks_reg > timeout_ticks_reg;
    assign track_now = tracking_valid_reg && !timed_out;
    assign nearer    = frame_nearest_reg > in_range_reg;

    assign avg_range = blend($signed({1'b0, held_range_reg}),
                             $signed({1'b0, in_range_reg}), alpha_eff);
    assign avg_speed = blend($signed({{3{held_speed_reg[FIELD_W-1]}}, held_speed_reg}),
                             $signed({{3{in_speed_reg[FIELD_W-1]}}, in_speed_reg}),
                             alpha_eff);
    assign avg_azimuth = blend(
        $signed({{3{held_azimuth_reg[FIELD_W-1]}}, held_azimuth_reg}),
        $signed({{3{in_azimuth_reg[FIELD_W-1]}}, in_azimuth_reg}), alpha_eff);
    assign avg_elevation = blend(
        $signed({{3{held_elevation_reg[FIELD_W-1]}}, held_elevation_reg}),
        $signed({{3{in_elevation_reg[FIELD_W-1]}}, in_elevation_reg}), alpha_eff);

    always_comb
    begin
        held_range_next     = held_range_reg;
        held_speed_next     = held_speed_reg;
        held_azimuth_next   = held_azimuth_reg;
        held_elevation_next = held_elevation_reg;
        tracking_valid_next = tracking_valid_reg;
        frame_nearest_next  = frame_nearest_reg;
        ticks_next          = ticks_reg;
        if (in_fire)
        begin
            unique case (in_op_reg)
                OP_DETECTION:
                begin
                    if (in_gate)
                    begin
                        tracking_valid_next = track_now;
                        if (nearer)
                        begin
                            if (smoothing_on_reg && track_now)
                            begin
                                held_range_next     = avg_range[RANGE_W-1:0];
                                held_speed_next     = avg_speed[FIELD_W-1:0];
                                held_azimuth_next   = avg_azimuth[FIELD_W-1:0];
                                held_elevation_next = avg_elevation[FIELD_W-1:0];
                            end
                            else
                            begin
                                held_range_next     = in_range_reg;
                                held_speed_next     = in_speed_reg;
                                held_azimuth_next   = in_azimuth_reg;
                                held_elevation_next = in_elevation_reg;
                                if (smoothing_on_reg)
                                begin
                                    tracking_valid_next = 1'b1;
                                end
                            end
                            frame_nearest_next = in_range_reg;
                        end
                    end
                end
                OP_FRAME_END:
                begin
                    ticks_next         = '0;
                    frame_nearest_next = ONE_KM_LIMIT;
                end
                OP_TICK:
                begin
                    if (ticks_reg < TICK_MAX)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_range_reg     <= '0;
            held_speed_reg     <= '0;
            held_azimuth_reg   <= '0;
            held_elevation_reg <= '0;
            tracking_valid_reg <= 1'b0;
            frame_nearest_reg  <= ONE_KM_LIMIT;
            ticks_reg          <= '0;
        end
        else
        begin
            held_range_reg     <= held_range_next;
            held_speed_reg     <= held_speed_next;
            held_azimuth_reg   <= held_azimuth_next;
            held_elevation_reg <= held_elevation_next;
            tracking_valid_reg <= tracking_valid_next;
            frame_nearest_reg  <= frame_nearest_next;
            ticks_reg          <= ticks_next;
        end
    end

    // Result register.
    logic out_load;

    assign out_load = in_fire && emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {6'd0, held_elevation_reg, held_azimuth_reg,
                             held_speed_reg, held_range_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Assertions.
    `NTGE_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
    `NTGE_ASSERT(a_nearest_bound, frame_nearest_reg <= ONE_KM_LIMIT,
        "frame minimum above 1000 m")
    `NTGE_ASSERT(a_no_overwrite, (out_valid_reg && !m_tready) |-> !out_load,
        "result overwritten while stalled")
    `NTGE_ASSERT(a_load_shows, out_load |=> m_tvalid, "loaded result not presented")
    `NTGE_ASSERT(a_track_needs_smooth,
        $rose(tracking_valid_reg) |-> $past(smoothing_on_reg),
        "tracking set with smoothing off")
    `NTGE_ASSERT(a_frame_end_clears,
        (in_fire && in_is_frame_end) |=>
            (ticks_reg == '0 && frame_nearest_reg == ONE_KM_LIMIT),
        "frame end did not restart frame")

endmodule

// File: tb/ntge_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the nearest target gate block: follows the register writes,
// predicts the held target reported at each frame end and checks the result
// channel field by field. Depends on ntge_pkg.

module ntge_checker
    import ntge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  drain_done,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic [FIELD_W-1:0] speed;
        logic [FIELD_W-1:0] azimuth;
        logic [FIELD_W-1:0] elevation;
    } target_t;

    target_t targets_due[$];

    // Register copies.
    logic [RANGE_W-1:0] gate_lo;
    logic [RANGE_W-1:0] gate_hi;
    logic               smooth_en;
    logic [ALPHA_W-1:0] weight;
    logic [TICK_W-1:0]  timeout;

    // Tracker state.
    logic [RANGE_W-1:0]        held_rng;
    logic signed [FIELD_W-1:0] held_spd;
    logic signed [FIELD_W-1:0] held_az;
    logic signed [FIELD_W-1:0] held_el;
    logic                      locked;
    logic [RANGE_W-1:0]        frame_nearest;
    logic [TICK_W-1:0]         ticks;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [RANGE_W-1:0] got,
                               input logic [RANGE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Arithmetic shift of the signed product is the floor towards minus infinity.
    function automatic longint pull_toward(longint cur, longint x, longint w);
        return cur + ((w * (x - cur)) >>> 16);
    endfunction

    task automatic take_detection(input logic [IN_DATA_W-1:0] d);
        logic [RANGE_W-1:0]        r;
        logic signed [FIELD_W-1:0] sp;
        logic signed [FIELD_W-1:0] az;
        logic signed [FIELD_W-1:0] el;
        longint                    w;
        r  = d[17:0];
        sp = d[33:18];
        az = d[49:34];
        el = d[65:50];
        w  = longint'((weight > ALPHA_ONE) ? ALPHA_ONE : weight);
        if (r < gate_lo || r > gate_hi)
            return;
        if (ticks > timeout)
            locked = 1'b0;
        if (frame_nearest > r)
        begin
            if (smooth_en && locked)
            begin
                held_rng = RANGE_W'(pull_toward(longint'(held_rng), longint'(r), w));
                held_spd = FIELD_W'(pull_toward(longint'(held_spd), longint'(sp), w));
                held_az  = FIELD_W'(pull_toward(longint'(held_az), longint'(az), w));
                held_el  = FIELD_W'(pull_toward(longint'(held_el), longint'(el), w));
            end
            else
            begin
                held_rng = r;
                held_spd = sp;
                held_az  = az;
                held_el  = el;
                if (smooth_en)
                    locked = 1'b1;
            end
            frame_nearest = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        target_t want;
        target_t due;
        if (!rst_n)
        begin
            targets_due.delete();
            gate_lo       = MIN_RANGE_RST;
            gate_hi       = MAX_RANGE_RST;
            smooth_en     = 1'b0;
            weight        = ALPHA_RST;
            timeout       = TIMEOUT_RST;
            held_rng      = '0;
            held_spd      = '0;
            held_az       = '0;
            held_el       = '0;
            locked        = 1'b0;
            frame_nearest = ONE_KM_LIMIT;
            ticks         = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (targets_due.size() == 0)
                    report_mismatch("result with no frame end waiting");
                else
                begin
                    want = targets_due.pop_front();
                    check_field("out_range", m_tdata[17:0], want.rng);
                    check_field("out_speed", RANGE_W'(m_tdata[33:18]),
                                RANGE_W'(want.speed));
                    check_field("out_azimuth", RANGE_W'(m_tdata[49:34]),
                                RANGE_W'(want.azimuth));
                    check_field("out_elevation", RANGE_W'(m_tdata[65:50]),
                                RANGE_W'(want.elevation));
                    check_field("padding", RANGE_W'(m_tdata[71:66]), '0);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MIN_RANGE: gate_lo   = pwdata[RANGE_W-1:0];
                    REG_MAX_RANGE: gate_hi   = pwdata[RANGE_W-1:0];
                    REG_SMOOTHING: smooth_en = pwdata[0];
                    REG_ALPHA:     weight    = pwdata[ALPHA_W-1:0];
                    REG_TIMEOUT:   timeout   = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    OP_DETECTION: take_detection(s_tdata);
                    OP_FRAME_END:
                    begin
                        if (held_rng < ONE_KM_LIMIT)
                        begin
                            due.rng       = held_rng;
                            due.speed     = held_spd;
                            due.azimuth   = held_az;
                            due.elevation = held_el;
                            targets_due.insert(targets_due.size(), due);
                        end
                        ticks = '0;
                        frame_nearest = ONE_KM_LIMIT;
                    end
                    OP_TICK:
                    begin
                        if (ticks != TICK_MAX)
                            ticks++;
                    end
                    default: ;
                endcase
            end
        end
        pending = targets_due.size();
    end

    always @(posedge drain_done)
    begin
        if (targets_due.size() != 0)
            report_mismatch($sformatf("%0d frame results never arrived", targets_due.size()));
    end

endmodule

// File: tb/tb_nearest_target_gate_ema.sv
`timescale 1ns / 1ps
// Top of the nearest target gate testbench: clock, reset, register setup and
// request stimulus with random idling on both channels, plus the verdict.
// Depends on ntge_pkg, nearest_target_gate_ema and ntge_checker.

module tb_nearest_target_gate_ema;
    import ntge_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         LONG_HOLD = 400;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [4:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  drain_done;
    int                    fail_count;
    int                    pending;
    int                    delivered = 0;
    int                    sent = 0;

    // Gate window now programmed; random detections are mostly aimed into it.
    logic [RANGE_W-1:0] aim_lo;
    logic [RANGE_W-1:0] aim_hi;

    nearest_target_gate_ema dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ntge_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .drain_done (drain_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            delivered <= delivered + 1;
    end

    // Result side: short and long stalls, quiet stretches, and one long hold
    // so that the result register and the input register back up.
    initial
    begin
        int  pick;
        bit  pressure_done;
        pressure_done = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (!pressure_done && delivered >= 40)
            begin
                pressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (pick < 15)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (pick < 18)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (pick < 22)
            begin
                m_tready <= 1'b1;
                repeat (60) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Called and returning at a falling edge.
    task automatic send_request(input logic [1:0] op, input logic [RANGE_W-1:0] rng,
                                input logic [FIELD_W-1:0] spd, az, el, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, el, az, spd, rng};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Detections after the last frame end may still be in the pipeline, so
    // the task waits after the last result before registers change.
    task automatic configure(input logic [RANGE_W-1:0] lo, hi, input logic sm,
                             input logic [ALPHA_W-1:0] a, input logic [TICK_W-1:0] t);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        write_reg(REG_MIN_RANGE, 32'(lo));
        write_reg(REG_MAX_RANGE, 32'(hi));
        write_reg(REG_SMOOTHING, 32'(sm));
        write_reg(REG_ALPHA, 32'(a));
        write_reg(REG_TIMEOUT, 32'(t));
        aim_lo = lo;
        aim_hi = hi;
    endtask

    task automatic random_setting(input bit empty_gate);
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic [ALPHA_W-1:0] a;
        logic [TICK_W-1:0]  t;
        case ($urandom_range(0, 2))
            0:       lo = '0;
            1:       lo = RANGE_W'($urandom_range(0, 2000));
            default: lo = RANGE_W'($urandom_range(0, 200000));
        endcase
        case ($urandom_range(0, 2))
            0:       hi = '1;
            1:       hi = lo + RANGE_W'($urandom_range(0, 3));
            default: hi = RANGE_W'($urandom_range(262143, lo));
        endcase
        if (empty_gate)
        begin
            lo = RANGE_W'($urandom_range(1, 262143));
            hi = RANGE_W'($urandom_range(0, lo - 1));
        end
        case ($urandom_range(0, 6))
            0:       a = '0;
            1:       a = 17'd1;
            2:       a = ALPHA_ONE;
            3:       a = ALPHA_ONE + 17'd1;
            4:       a = '1;
            default: a = ALPHA_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 4))
            0:       t = '0;
            1:       t = 16'd1;
            2:       t = TICK_W'($urandom_range(2, 12));
            3:       t = TIMEOUT_RST;
            default: t = '1;
        endcase
        configure(lo, hi, $urandom_range(0, 3) != 0, a, t);
    endtask

    // One frame: detections with ticks scattered among them, then a frame end.
    task automatic random_frame();
        bit                 burst;
        int                 n_dets;
        logic [RANGE_W-1:0] r;
        burst  = ($urandom_range(0, 4) == 0);
        n_dets = $urandom_range(1, 6);
        repeat (n_dets)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6))
                    send_request(OP_TICK, RANGE_W'($urandom), FIELD_W'($urandom),
                                 FIELD_W'($urandom), FIELD_W'($urandom),
                                 burst ? 0 : pick_gap());
            if (aim_lo <= aim_hi && $urandom_range(0, 9) != 0)
                r = RANGE_W'($urandom_range(aim_hi, aim_lo));
            else
                r = RANGE_W'($urandom);
            send_request(OP_DETECTION, r, FIELD_W'($urandom), FIELD_W'($urandom),
                         FIELD_W'($urandom), burst ? 0 : pick_gap());
        end
        send_request(OP_FRAME_END, RANGE_W'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom), FIELD_W'($urandom), burst ? 0 : pick_gap());
    endtask

    initial
    begin
        int phase_end;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_DETECTION;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        drain_done = 1'b0;
        aim_lo     = MIN_RANGE_RST;
        aim_hi     = MAX_RANGE_RST;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register defaults. Nothing is held yet, so the first frame end
        // reports the reset target of range zero.
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);
        send_request(OP_UNUSED, '1, '1, '1, '1, 0);
        send_request(OP_DETECTION, MAX_RANGE_RST, 16'h7FFF, 16'h8000, 16'h0000, 0);
        send_request(OP_DETECTION, MAX_RANGE_RST + 18'd1, 16'h1234, 16'h4321, 16'h0F0F, 1);
        send_request(OP_DETECTION, '1, '1, '1, '1, 0);
        send_request(OP_DETECTION, 18'd100, 16'h8000, 16'h7FFF, 16'hFFFF, 2);
        send_request(OP_DETECTION, '0, 16'h7FFF, 16'h8000, 16'h0001, 0);
        send_request(OP_TICK, '0, '0, '0, '0, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);

        // Smoothing with a weight above one, and a timeout of one tick.
        configure(18'd5, 18'd200000, 1'b1, '1, 16'd1);
        send_request(OP_DETECTION, 18'd3, 16'h5555, 16'hAAAA, 16'h5555, 0);
        send_request(OP_DETECTION, 18'd150000, 16'h0400, 16'hFC00, 16'h0100, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);
        send_request(OP_DETECTION, 18'd100000, 16'hF000, 16'h0300, 16'hFF00, 0);
        send_request(OP_TICK, '0, '0, '0, '0, 0);
        send_request(OP_TICK, '0, '0, '0, '0, 0);
        send_request(OP_DETECTION, 18'd50000, 16'h8001, 16'h7FFE, 16'h8000, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);

        // Half weight exercises the floor on negative steps, then a run of
        // ticks that stays under the timeout keeps tracking alive.
        configure(18'd5, 18'd200000, 1'b1, 17'd32768, 16'd65534);
        send_request(OP_DETECTION, 18'd40001, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);
        repeat (20)
            send_request(OP_TICK, RANGE_W'($urandom), FIELD_W'($urandom),
                         FIELD_W'($urandom), FIELD_W'($urandom), 0);
        send_request(OP_DETECTION, 18'd30000, 16'h0123, 16'hFEDC, 16'h0042, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);

        // Empty gate: nothing may count.
        configure(18'd1000, 18'd999, 1'b0, ALPHA_RST, TIMEOUT_RST);
        send_request(OP_DETECTION, 18'd1000, 16'h1111, 16'h2222, 16'h3333, 0);
        send_request(OP_DETECTION, 18'd999, 16'h4444, 16'h5555, 16'h6666, 0);
        send_request(OP_FRAME_END, '0, '0, '0, '0, 0);

        for (int phase = 0; phase < 6; phase++)
        begin
            random_setting(phase == 3);
            phase_end = sent + 90;
            while (sent < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_request(2'($urandom_range(0, 3)), RANGE_W'($urandom),
                                 FIELD_W'($urandom), FIELD_W'($urandom),
                                 FIELD_W'($urandom), pick_gap());
                else
                    random_frame();
            end
        end

        s_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && pending != 0; w++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        drain_done <= 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
